// ===== hw/rtl/polyphase_rational_resampler_unit_assert.svh =====
// assertion macros for the polyphase resampler
// clocked on clock, disabled while reset is high
`ifndef POLYPHASE_RATIONAL_RESAMPLER_UNIT_ASSERT_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define PRR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/prr_pkg.sv =====
// shared types and constants of the polyphase resampler
// no dependencies
`default_nettype none

package prr_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int COEF_BITS    = 18;
   localparam int FRAC_BITS    = COEF_BITS - 2;
   localparam int CHANNELS     = 2;
   localparam int COEF_INDEX_W = 9;
   localparam int UP_W         = 5;
   localparam int DOWN_W       = 7;
   localparam int TAPS_REG_W   = 6;
   localparam int PHASE_W      = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_UP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS = 2'd2;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/prr_req_if.sv =====
// request channel: sample push or coefficient write word
// depends on prr_pkg
`default_nettype none

interface prr_req_if import prr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic                          channel;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [COEF_INDEX_W-1:0]       coef_index;
   logic signed [COEF_BITS-1:0]   coef_value;

   modport source (output valid, cmd, channel, sample, coef_index, coef_value,
                   input ready);
   modport sink (input valid, cmd, channel, sample, coef_index, coef_value,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prr_rsp_if.sv =====
// response channel: one resampled output word
// depends on prr_pkg
`default_nettype none

interface prr_rsp_if import prr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          out_channel;
   logic                          last;

   modport source (output valid, out_sample, out_channel, last, input ready);
   modport sink (input valid, out_sample, out_channel, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prr_csr_if.sv =====
// configuration write channel: register index and data word
// depends on prr_pkg
`default_nettype none

interface prr_csr_if import prr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/polyphase_rational_resampler_unit.sv =====
// polyphase rational resampler, two channels, one shared 18x16 multiply-accumulate
// coefficient writes and decimated samples are taken while idle; each output runs
// prep, mac over the taps, drain and round, and a sample busies the block until its
// last output is loaded, as the single mac and its memory reads serve each output
// synchronous reset: control and config registers, history reads zero via fill counts
// depends on prr_pkg, prr_req_if, prr_rsp_if, prr_csr_if and the assertion header
`default_nettype none
`include "polyphase_rational_resampler_unit_assert.svh"

module polyphase_rational_resampler_unit import prr_pkg::*; #(
   parameter int MAX_TAPS = 32,
   parameter int MAX_UP   = 16
) (
   input  wire        clock,
   input  wire        reset,
   prr_req_if.sink    req_ch,
   prr_rsp_if.source  rsp_ch,
   prr_csr_if.sink    csr_ch
);

   localparam int TABLE_SIZE = MAX_UP * MAX_TAPS;
   localparam int CA_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int SLOT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int SUM_W  = SLOT_W + 2;
   localparam int TAPS_W = $clog2(MAX_TAPS + 1);
   localparam int UPC_W  = $clog2(MAX_UP + 1);
   localparam int WPH_W  = PHASE_W + 1;
   localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + TAPS_W + 1;
   localparam logic signed [ACC_W-1:0] ROUND_ADD =
      {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   // configuration
   logic [UP_W-1:0]       up_ff;
   logic [DOWN_W-1:0]     down_ff;
   logic [TAPS_REG_W-1:0] taps_ff;

   // control
   state_type             state_ff, state_in;
   logic [PHASE_W-1:0]    phase_ff [CHANNELS];
   logic [SLOT_W-1:0]     wp_ff [CHANNELS];
   logic [TAPS_W-1:0]     cnt_ff [CHANNELS];
   logic                  ch_ff;
   logic [UPC_W-1:0]      up_use_ff;
   logic [DOWN_W-1:0]     down_use_ff;
   logic [TAPS_W-1:0]     taps_use_ff;
   logic [WPH_W-1:0]      ph_ff;
   logic [TAPS_W-1:0]     issue_cnt_ff;
   logic [CA_W-1:0]       coef_addr_ff;
   logic [SLOT_W-1:0]     hist_addr_ff;
   logic                  rd_v_ff;
   logic                  mul_v_ff;
   logic                  rsp_valid_ff;

   // datapath
   logic signed [COEF_BITS-1:0]   coef_rd_ff;
   logic signed [SAMPLE_BITS-1:0] hist_rd_ff;
   logic                          zero_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_channel_ff;
   logic                          last_ff;

   logic signed [COEF_BITS-1:0]   coef_mem [TABLE_SIZE];
   logic signed [SAMPLE_BITS-1:0] hist_mem [CHANNELS][MAX_TAPS];

   logic                  accept;
   logic                  is_sample;
   logic                  is_coef;
   logic                  due;
   logic                  out_load;
   logic                  out_last;
   logic                  slot_free;
   logic [UPC_W-1:0]      up_eff;
   logic [DOWN_W-1:0]     down_eff;
   logic [TAPS_W-1:0]     taps_eff;
   logic [PHASE_W-1:0]    phase_cur;
   logic [WPH_W-1:0]      ph_next;
   logic [SLOT_W-1:0]     wp_new;
   logic [SUM_W-1:0]      start_sum;
   logic [SLOT_W-1:0]     start_addr;
   logic [TAPS_W-1:0]     age;
   logic signed [ACC_W-1:0] rnd_sum;
   logic signed [ACC_W-1:0] rnd_shift;
   logic signed [ACC_W-1:0] rnd_sat;

   // effective register values
   always_comb begin
      if (up_ff == '0) begin
         up_eff = UPC_W'(1);
      end else if (32'(up_ff) > MAX_UP) begin
         up_eff = UPC_W'(MAX_UP);
      end else begin
         up_eff = UPC_W'(up_ff);
      end
      down_eff = (down_ff == '0) ? DOWN_W'(1) : down_ff;
      if (taps_ff == '0) begin
         taps_eff = TAPS_W'(1);
      end else if (32'(taps_ff) > MAX_TAPS) begin
         taps_eff = TAPS_W'(MAX_TAPS);
      end else begin
         taps_eff = TAPS_W'(taps_ff);
      end
   end

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_coef      = accept && (req_ch.cmd == CMD_COEF) &&
                         (32'(req_ch.coef_index) < TABLE_SIZE);
   assign is_sample    = accept && (req_ch.cmd == CMD_SAMPLE) &&
                         (32'(req_ch.channel) < CHANNELS);
   assign phase_cur    = phase_ff[req_ch.channel];
   assign due          = (phase_cur < up_eff);
   assign ph_next      = WPH_W'(ph_ff + down_use_ff);
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign wp_new       = (32'(wp_ff[req_ch.channel]) == MAX_TAPS - 1) ? '0 :
                         SLOT_W'(wp_ff[req_ch.channel] + 1'b1);
   assign start_sum    = SUM_W'(wp_ff[ch_ff]) + SUM_W'(MAX_TAPS) -
                         SUM_W'(taps_use_ff - 1'b1);
   assign start_addr   = (32'(start_sum) >= MAX_TAPS) ?
                         SLOT_W'(start_sum - SUM_W'(MAX_TAPS)) : SLOT_W'(start_sum);
   assign age          = TAPS_W'(taps_use_ff - 1'b1 - issue_cnt_ff);

   // round to nearest, then saturate
   assign rnd_sum   = acc_ff + ROUND_ADD;
   assign rnd_shift = rnd_sum >>> FRAC_BITS;
   assign rnd_sat   = (rnd_shift > SAT_HI) ? SAT_HI :
                      (rnd_shift < SAT_LO) ? SAT_LO : rnd_shift;

   // sequencer
   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      out_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (is_sample && due) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (issue_cnt_ff == TAPS_W'(taps_use_ff - 1'b1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !mul_v_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (slot_free) begin
               out_load = 1'b1;
               if (ph_next < up_use_ff) begin
                  state_in = ST_PREP;
               end else begin
                  out_last = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= UP_W'(1);
         down_ff <= DOWN_W'(1);
         taps_ff <= TAPS_REG_W'(32);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_UP:   up_ff   <= csr_ch.data[UP_W-1:0];
            CSR_DOWN: down_ff <= csr_ch.data[DOWN_W-1:0];
            CSR_TAPS: taps_ff <= csr_ch.data[TAPS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // per-channel phase, write pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            phase_ff[c] <= '0;
            wp_ff[c]    <= '0;
            cnt_ff[c]   <= '0;
         end
      end else begin
         if (is_sample) begin
            wp_ff[req_ch.channel] <= wp_new;
            if (32'(cnt_ff[req_ch.channel]) != MAX_TAPS) begin
               cnt_ff[req_ch.channel] <= TAPS_W'(cnt_ff[req_ch.channel] + 1'b1);
            end
            if (!due) begin
               phase_ff[req_ch.channel] <= PHASE_W'(phase_cur - up_eff);
            end
         end
         if (out_load && out_last) begin
            phase_ff[ch_ff] <= PHASE_W'(ph_next - up_use_ff);
         end
      end
   end

   // run registers and address counters
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= (state_ff == ST_MAC);
         mul_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (is_sample) begin
         ch_ff       <= req_ch.channel;
         up_use_ff   <= up_eff;
         down_use_ff <= down_eff;
         taps_use_ff <= taps_eff;
         ph_ff       <= WPH_W'(phase_cur);
      end
      if (out_load && !out_last) begin
         ph_ff <= ph_next;
      end
      case (state_ff)
         ST_PREP: begin
            coef_addr_ff <= CA_W'(ph_ff * taps_use_ff);
            hist_addr_ff <= start_addr;
            issue_cnt_ff <= '0;
         end
         ST_MAC: begin
            coef_addr_ff <= CA_W'(coef_addr_ff + 1'b1);
            hist_addr_ff <= (32'(hist_addr_ff) == MAX_TAPS - 1) ? '0 :
                            SLOT_W'(hist_addr_ff + 1'b1);
            issue_cnt_ff <= TAPS_W'(issue_cnt_ff + 1'b1);
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (is_coef) begin
         coef_mem[CA_W'(req_ch.coef_index)] <= req_ch.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (is_sample) begin
         hist_mem[req_ch.channel][wp_new] <= req_ch.sample;
      end
      hist_rd_ff <= hist_mem[ch_ff][hist_addr_ff];
   end

   // shared multiply-accumulate
   always_ff @(posedge clock) begin
      zero_ff <= (age >= cnt_ff[ch_ff]);
      if (zero_ff) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= coef_rd_ff * hist_rd_ff;
      end
      if (state_ff == ST_PREP) begin
         acc_ff <= '0;
      end else if (mul_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_sample_ff  <= SAMPLE_BITS'(rnd_sat);
         out_channel_ff <= ch_ff;
         last_ff        <= out_last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_sample  = out_sample_ff;
   assign rsp_ch.out_channel = out_channel_ff;
   assign rsp_ch.last        = last_ff;

   `PRR_ASSERT_NOW(a_issue_in_range, state_ff == ST_MAC,
      issue_cnt_ff < taps_use_ff, "tap issue count beyond tap count")
   `PRR_ASSERT_NOW(a_load_slot_free, out_load,
      !rsp_valid_ff || rsp_ch.ready, "output word overwritten before taken")
   `PRR_ASSERT_NOW(a_mac_pipe_busy, rd_v_ff || mul_v_ff,
      state_ff == ST_MAC || state_ff == ST_DRAIN, "mac pipeline active outside run")
   `PRR_ASSERT_NEXT(a_last_to_idle, out_load && out_last,
      state_ff == ST_IDLE, "no return to idle after last word")

endmodule

`default_nettype wire

// ===== verif/polyphase_rational_resampler_unit_tb.sv =====
// polyphase resampler testbench: directed table, then fixed and random config phases
// every output word is checked against a polyphase predictor kept inside this file
// depends on prr_pkg, prr_req_if, prr_rsp_if, prr_csr_if and the resampler rtl

module polyphase_rational_resampler_unit_tb;
   import prr_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int MAX_TAPS     = 32;
   localparam int MAX_UP       = 16;
   localparam int TABLE_SIZE   = MAX_UP * MAX_TAPS;
   localparam int FILL_WORDS   = 128;
   localparam int LIMIT        = 2_000_000;
   localparam int DRAIN_CYCLES = 80;
   localparam int END_WAIT     = 20_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_PCT     = 7;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 15;
   localparam int N_DIRECTED   = 35;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {
      ROW_SAMPLE,
      ROW_COEF,
      ROW_REG
   } row_kind_type;

   typedef struct packed {
      logic                          cmd;
      logic                          chan;
      logic signed [SAMPLE_BITS-1:0] smp;
      logic [COEF_INDEX_W-1:0]       cidx;
      logic signed [COEF_BITS-1:0]   cval;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] smp;
      logic                          chan;
      logic                          last;
   } out_word_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic                          chan;
      logic signed [SAMPLE_BITS-1:0] smp;
      logic [COEF_INDEX_W-1:0]       cidx;
      logic signed [COEF_BITS-1:0]   cval;
      logic [CSR_INDEX_W-1:0]        reg_idx;
      logic [CSR_DATA_W-1:0]         reg_data;
      logic                          typed;
      logic signed [SAMPLE_BITS-1:0] typed_out;
   } dir_row_type;

   // kind, channel, sample, coef index, coef value, register, data, typed, expected sample
   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      '{ROW_COEF,   1'b0, 16'sd0,      9'd31, 18'sd65536,  CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, 16'sd1234,   9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sd1234},
      '{ROW_SAMPLE, 1'b1, -16'sd1234,  9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, -16'sd1234},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_TAPS,  7'd1,  1'b0, 16'sd0},
      '{ROW_COEF,   1'b0, 16'sd0,      9'd0,  18'sd65536,  CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, 16'sd32767,  9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sd32767},
      '{ROW_SAMPLE, 1'b0, 16'sh8000,   9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sh8000},
      '{ROW_COEF,   1'b0, 16'sd0,      9'd0,  18'sd131071, CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b1, 16'sd32767,  9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sd32767},
      '{ROW_SAMPLE, 1'b1, 16'sh8000,   9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sh8000},
      '{ROW_COEF,   1'b0, 16'sd0,      9'd0,  18'sh20000,  CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, 16'sh8000,   9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sd32767},
      '{ROW_SAMPLE, 1'b0, 16'sd32767,  9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sh8000},
      '{ROW_COEF,   1'b0, 16'sd0,      9'd0,  18'sd32768,  CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b1, 16'sd1,      9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sd1},
      '{ROW_SAMPLE, 1'b1, -16'sd1,     9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, 16'sd100,    9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b1, 16'sd50},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_UP,    7'd31, 1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_DOWN,  7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, -16'sd7000,  9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_UP,    7'd4,  1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_TAPS,  7'd63, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b1, 16'sd12345,  9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_UP,    7'd3,  1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_DOWN,  7'd64, 1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_TAPS,  7'd5,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, 16'sd555,    9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, -16'sd555,   9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b1, 16'sd4096,   9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_SPARE, 7'h55, 1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_UP,    7'd2,  1'b0, 16'sd0},
      '{ROW_REG,    1'b0, 16'sd0,      9'd0,  18'sd0,      CSR_DOWN,  7'd3,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b0, 16'sd777,    9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0},
      '{ROW_SAMPLE, 1'b1, -16'sd777,   9'd0,  18'sd0,      CSR_UP,    7'd0,  1'b0, 16'sd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   prr_req_if req_bus ();
   prr_rsp_if rsp_bus ();
   prr_csr_if csr_bus ();

   polyphase_rational_resampler_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // predictor state
   logic [UP_W-1:0]               up_reg;
   logic [DOWN_W-1:0]             down_reg;
   logic [TAPS_REG_W-1:0]         taps_reg;
   logic signed [SAMPLE_BITS-1:0] hist [CHANNELS][MAX_TAPS];
   logic signed [COEF_BITS-1:0]   coef_mem [TABLE_SIZE];
   logic [PHASE_W-1:0]            phase_st [CHANNELS];
   out_word_type                  expected_out [$];

   out_word_type want;
   int        fail_count = 0;
   logic      quiet = 1'b0;
   int        hold_stamp = 0;
   int        hold_seen = 0;
   int        hold_left = 0;

   always #HALF_PERIOD clock = ~clock;

   task automatic resample_word(input req_word_type w, input logic typed,
                                input logic signed [SAMPLE_BITS-1:0] typed_out);
      int        up_eff;
      int        down_eff;
      int        taps_eff;
      int        ph;
      int        n;
      longint    acc;
      out_word_type r;
      if (w.cmd == CMD_COEF) begin
         coef_mem[w.cidx] = w.cval;
         return;
      end
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
         hist[w.chan][i] = hist[w.chan][i-1];
      end
      hist[w.chan][0] = w.smp;
      up_eff   = (up_reg == 0) ? 1 : ((up_reg > MAX_UP) ? MAX_UP : int'(up_reg));
      down_eff = (down_reg == 0) ? 1 : int'(down_reg);
      taps_eff = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg));
      ph = int'(phase_st[w.chan]);
      n  = 0;
      while (ph < up_eff && n < MAX_UP) begin
         acc = 0;
         // last tap meets the newest sample
         for (int j = 0; j < taps_eff; j++) begin
            acc += longint'(coef_mem[ph * taps_eff + j]) *
                   longint'(hist[w.chan][taps_eff - 1 - j]);
         end
         acc = (acc + 64'sd32768) >>> FRAC_BITS;
         if (acc > 32767) begin
            r.smp = 16'sh7FFF;
         end else if (acc < -32768) begin
            r.smp = 16'sh8000;
         end else begin
            r.smp = acc[SAMPLE_BITS-1:0];
         end
         if (typed) begin
            r.smp = typed_out;
         end
         r.chan = w.chan;
         n++;
         ph += down_eff;
         r.last = (ph >= up_eff) || (n == MAX_UP);
         expected_out.push_back(r);
      end
      ph = (ph >= up_eff) ? ph - up_eff : 0;
      phase_st[w.chan] = PHASE_W'(ph);
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      w.cmd  = ($urandom_range(99) < 15) ? CMD_COEF : CMD_SAMPLE;
      w.chan = 1'($urandom_range(1));
      w.cidx = COEF_INDEX_W'($urandom);
      w.cval = COEF_BITS'($urandom);
      case ($urandom_range(9))
         0: w.smp = 16'sh7FFF;
         1: w.smp = 16'sh8000;
         2: w.smp = -16'sd1;
         default: w.smp = SAMPLE_BITS'($urandom);
      endcase
      return w;
   endfunction

   task automatic send_word(input req_word_type w, input logic typed,
                            input logic signed [SAMPLE_BITS-1:0] typed_out);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.cmd        = w.cmd;
      req_bus.channel    = w.chan;
      req_bus.sample     = w.smp;
      req_bus.coef_index = w.cidx;
      req_bus.coef_value = w.cval;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      resample_word(w, typed, typed_out);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_UP:   up_reg   = data[UP_W-1:0];
         CSR_DOWN: down_reg = data[DOWN_W-1:0];
         CSR_TAPS: taps_reg = data[TAPS_REG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
   endtask

   // decimated samples and coefficient words leave no trace in the queue
   task automatic settle();
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // output word check
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_out.size() == 0) begin
            if (fail_count < MAX_REPORTS) begin
               $display("unexpected word: sample %0d channel %0d last %0d",
                        rsp_bus.out_sample, rsp_bus.out_channel, rsp_bus.last);
            end
            fail_count++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_bus.out_sample !== want.smp || rsp_bus.out_channel !== want.chan ||
                rsp_bus.last !== want.last) begin
               if (fail_count < MAX_REPORTS) begin
                  $display("mismatch: expected sample %0d channel %0d last %0d, got %0d %0d %0d",
                           want.smp, want.chan, want.last, rsp_bus.out_sample,
                           rsp_bus.out_channel, rsp_bus.last);
               end
               fail_count++;
            end
         end
      end
   end

   // output side backpressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_stamp) begin
            hold_seen = hold_stamp;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int cycle;
      for (cycle = 0; cycle < LIMIT; cycle++) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      req_word_type             w;
      logic [CSR_DATA_W-1:0] up_d;
      logic [CSR_DATA_W-1:0] down_d;
      logic [CSR_DATA_W-1:0] taps_d;
      int                       waited;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_SAMPLE;
      req_bus.channel    = 1'b0;
      req_bus.sample     = '0;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_UP;
      csr_bus.data       = '0;
      up_reg   = UP_W'(1);
      down_reg = DOWN_W'(1);
      taps_reg = TAPS_REG_W'(MAX_TAPS);
      for (int c = 0; c < CHANNELS; c++) begin
         phase_st[c] = '0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            hist[c][i] = '0;
         end
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the low part of the table, every setting below reads only inside it
      for (int i = 0; i < FILL_WORDS; i++) begin
         w      = random_word();
         w.cmd  = CMD_COEF;
         w.cidx = COEF_INDEX_W'(i);
         send_word(w, 1'b0, '0);
      end

      for (int r = 0; r < N_DIRECTED; r++) begin
         if (DIRECTED[r].kind == ROW_REG) begin
            settle();
            write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
         end else begin
            w.cmd  = (DIRECTED[r].kind == ROW_COEF) ? CMD_COEF : CMD_SAMPLE;
            w.chan = DIRECTED[r].chan;
            w.smp  = DIRECTED[r].smp;
            w.cidx = DIRECTED[r].cidx;
            w.cval = DIRECTED[r].cval;
            send_word(w, DIRECTED[r].typed, DIRECTED[r].typed_out);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               up_d   = CSR_DATA_W'($urandom_range(4, 2));
               down_d = CSR_DATA_W'($urandom_range(4, 1));
               taps_d = CSR_DATA_W'($urandom_range(6, 1));
            end
            1: begin
               up_d   = CSR_DATA_W'(MAX_UP);
               down_d = CSR_DATA_W'(1);
               taps_d = CSR_DATA_W'(8);
            end
            2: begin
               up_d   = CSR_DATA_W'(4);
               down_d = CSR_DATA_W'(3);
               taps_d = CSR_DATA_W'(4);
            end
            3: begin
               up_d   = CSR_DATA_W'(1);
               down_d = CSR_DATA_W'(127);
               taps_d = CSR_DATA_W'(8);
            end
            4: begin
               up_d   = CSR_DATA_W'($urandom);
               down_d = CSR_DATA_W'($urandom);
               taps_d = CSR_DATA_W'($urandom_range(8, 0));
            end
            5: begin
               up_d   = CSR_DATA_W'(3);
               down_d = CSR_DATA_W'(2);
               taps_d = CSR_DATA_W'(1);
            end
            6: begin
               up_d   = CSR_DATA_W'($urandom_range(16, 1));
               down_d = CSR_DATA_W'($urandom_range(20, 1));
               taps_d = CSR_DATA_W'($urandom_range(8, 1));
            end
            default: begin
               up_d   = CSR_DATA_W'(5);
               down_d = CSR_DATA_W'(5);
               taps_d = CSR_DATA_W'(3);
            end
         endcase
         write_reg(CSR_UP, up_d);
         write_reg(CSR_DOWN, down_d);
         write_reg(CSR_TAPS, taps_d);
         if (p == 5) begin
            write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
         end
         quiet = (p == 4);
         // long output stall while words keep coming
         if (p == 2) begin
            hold_stamp++;
         end
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(39) == 0) begin
               wait_results();
            end
            send_word(random_word(), 1'b0, '0);
         end
      end
      quiet = 1'b0;

      @(negedge clock);
      req_bus.valid = 1'b0;
      waited = 0;
      while (expected_out.size() != 0 && waited < END_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_out.size() != 0) begin
         $display("%0d expected output words never arrived", expected_out.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/prr_pkg.sv
hw/rtl/prr_req_if.sv
hw/rtl/prr_rsp_if.sv
hw/rtl/prr_csr_if.sv
hw/rtl/polyphase_rational_resampler_unit.sv
verif/polyphase_rational_resampler_unit_tb.sv
